// ----- sv/qts_pkg.sv -----
// ============================================================================
// Quoted token splitter package
// Types, character codes and error codes shared by the splitter modules.
// ============================================================================
`default_nettype none

package qts_pkg;

    // Character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_LEADING  = 3'd1;
    localparam logic [2:0] ERR_TRAILING = 3'd2;
    localparam logic [2:0] ERR_EMPTY    = 3'd3;
    localparam logic [2:0] ERR_UNTERM   = 3'd4;
    localparam logic [2:0] ERR_ESCAPED  = 3'd5;

    // Depth of the command queue between parser and result sequencer
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // Parser state
    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_Q_OPEN   = 3'd1,
        MODE_Q_BODY   = 3'd2,
        MODE_Q_CLOSED = 3'd3,
        MODE_DROP     = 3'd4
    } t_mode;

    // One queued command: the first result of a byte, and whether a second
    // result (the empty final token) follows it.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_end;
        logic       line_end;
        logic [2:0] error_code;
        logic       two;
    } t_cmd;

    // Queue status seen by the result sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

`default_nettype wire

// ----- sv/qts_front.sv -----
// ============================================================================
// Quoted token splitter parser
// Classifies each accepted byte against the quoting state and builds the
// command that describes the results it causes.
// ============================================================================
`default_nettype none

module qts_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic [7:0]   i_in_byte,
    input  wire logic         i_line_last,
    output qts_pkg::t_cmd     o_cmd,
    output logic              o_cmd_valid
);
    import qts_pkg::*;

    t_mode r_mode, n_mode;
    logic  r_prev_space, n_prev_space;
    logic  r_odd, n_odd;

    // State registers, updated once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_prev_space <= 1'b0;
            r_odd        <= 1'b0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_prev_space <= n_prev_space;
            r_odd        <= n_odd;
        end
    end

    // Classification of the byte and next parser state
    always_comb begin
        logic is_quote;
        logic is_space;
        logic is_bslash;
        logic last;
        logic err;
        logic [2:0] err_code;

        is_quote  = (i_in_byte == CH_QUOTE);
        is_space  = (i_in_byte == CH_SPACE);
        is_bslash = (i_in_byte == CH_BSLASH);
        last      = i_line_last;
        err       = 1'b0;
        err_code  = ERR_NONE;

        n_mode       = r_mode;
        n_prev_space = r_prev_space;
        n_odd        = r_odd;

        // By default the byte is passed on as a token character.
        o_cmd_valid      = 1'b1;
        o_cmd.out_byte   = i_in_byte;
        o_cmd.byte_valid = 1'b1;
        o_cmd.token_end  = 1'b0;
        o_cmd.line_end   = 1'b0;
        o_cmd.error_code = ERR_NONE;
        o_cmd.two        = 1'b0;

        unique case (r_mode)
            MODE_NORMAL: begin
                if (is_quote) begin
                    if (!r_prev_space) begin
                        err      = 1'b1;
                        err_code = ERR_LEADING;
                    end else if (last) begin
                        err      = 1'b1;
                        err_code = ERR_EMPTY;
                    end else begin
                        n_mode       = MODE_Q_OPEN;
                        n_prev_space = 1'b0;
                        n_odd        = 1'b0;
                    end
                end else if (is_space) begin
                    o_cmd.out_byte   = '0;
                    o_cmd.byte_valid = 1'b0;
                    o_cmd.token_end  = 1'b1;
                    o_cmd.two        = last;
                    n_mode           = MODE_NORMAL;
                    n_prev_space     = 1'b1;
                end else begin
                    o_cmd.token_end = last;
                    o_cmd.line_end  = last;
                    n_prev_space    = 1'b0;
                end
            end
            MODE_Q_OPEN: begin
                if (is_quote || last) begin
                    err      = 1'b1;
                    err_code = ERR_EMPTY;
                end else begin
                    n_odd  = is_bslash;
                    n_mode = MODE_Q_BODY;
                end
            end
            MODE_Q_BODY: begin
                if (is_quote) begin
                    if (r_odd) begin
                        if (last) begin
                            err      = 1'b1;
                            err_code = ERR_ESCAPED;
                        end else begin
                            n_odd = 1'b0;
                        end
                    end else if (last) begin
                        o_cmd.token_end = 1'b1;
                        o_cmd.line_end  = 1'b1;
                    end else begin
                        n_odd  = 1'b0;
                        n_mode = MODE_Q_CLOSED;
                    end
                end else if (last) begin
                    err      = 1'b1;
                    err_code = ERR_UNTERM;
                end else begin
                    n_odd = is_bslash ? ~r_odd : 1'b0;
                end
            end
            MODE_Q_CLOSED: begin
                if (is_space) begin
                    o_cmd.out_byte   = '0;
                    o_cmd.byte_valid = 1'b0;
                    o_cmd.token_end  = 1'b1;
                    o_cmd.two        = last;
                    n_mode           = MODE_NORMAL;
                    n_prev_space     = 1'b1;
                end else begin
                    err      = 1'b1;
                    err_code = ERR_TRAILING;
                end
            end
            default: begin
                // Dropping the rest of a failed line: no result at all.
                o_cmd_valid = 1'b0;
            end
        endcase

        // An error is reported once and the rest of the line is dropped.
        if (err) begin
            o_cmd.out_byte   = '0;
            o_cmd.byte_valid = 1'b0;
            o_cmd.token_end  = 1'b0;
            o_cmd.line_end   = 1'b1;
            o_cmd.error_code = err_code;
            o_cmd.two        = 1'b0;
            n_mode           = MODE_DROP;
        end

        // Every line end returns the parser to its reset state.
        if (last) begin
            n_mode       = MODE_NORMAL;
            n_prev_space = 1'b0;
            n_odd        = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/qts_fifo.sv -----
// ============================================================================
// Quoted token splitter command queue
// Short register queue that decouples the parser from the result sequencer.
// ============================================================================
`default_nettype none

module qts_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire qts_pkg::t_cmd  i_wr_cmd,
    input  wire logic           i_rd,
    output qts_pkg::t_cmd       o_head,
    output qts_pkg::t_qstat     o_stat
);
    import qts_pkg::*;

    t_cmd           r_mem [QDepth];
    logic [QAw-1:0] r_wr_ptr;
    logic [QAw-1:0] r_rd_ptr;
    logic [QAw:0]   r_count;
    logic           wr_en;
    logic           rd_en;

    assign wr_en = i_wr && (r_count != (QAw+1)'(QDepth));
    assign rd_en = i_rd && (r_count != '0);

    // Storage; entries need no reset
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + QAw'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + QAw'(1);
            end
            r_count <= r_count + (QAw+1)'(wr_en) - (QAw+1)'(rd_en);
        end
    end

    // Head of the queue and its status
    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (QAw+1)'(QDepth));

endmodule

`default_nettype wire

// ----- sv/qts_back.sv -----
// ============================================================================
// Quoted token splitter result sequencer
// Turns each queued command into one or two results on the output queue
// interface and retires the command after its last result.
// ============================================================================
`default_nettype none

module qts_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire qts_pkg::t_cmd    i_head,
    input  wire qts_pkg::t_qstat  i_stat,
    input  wire logic             i_pop,
    output logic                  o_q_rd,
    output logic                  o_empty,
    output logic [7:0]            o_out_byte,
    output logic                  o_byte_valid,
    output logic                  o_token_end,
    output logic                  o_line_end,
    output logic [2:0]            o_error_code,
    output logic                  o_item_last
);
    import qts_pkg::*;

    logic r_second;
    logic take;

    assign o_empty = i_stat.empty;
    assign take    = i_pop && !i_stat.empty;

    // Second-result phase of a two-result command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= i_head.two && !r_second;
        end
    end

    // The command leaves the queue with its last result.
    assign o_q_rd = take && (!i_head.two || r_second);

    // Result fields: the queued result, or the empty final token
    always_comb begin
        if (r_second) begin
            o_out_byte   = '0;
            o_byte_valid = 1'b0;
            o_token_end  = 1'b1;
            o_line_end   = 1'b1;
            o_error_code = ERR_NONE;
            o_item_last  = 1'b1;
        end else begin
            o_out_byte   = i_head.out_byte;
            o_byte_valid = i_head.byte_valid;
            o_token_end  = i_head.token_end;
            o_line_end   = i_head.line_end;
            o_error_code = i_head.error_code;
            o_item_last  = !i_head.two;
        end
    end

endmodule

`default_nettype wire

// ----- sv/quoted_token_splitter_top.sv -----
// ============================================================================
// Quoted token splitter
// Splits command lines, one byte per transaction, into space-separated
// tokens with double-quoted strings and reports malformed lines.
// ============================================================================
// Usage:
// Bytes enter through a queue-style port: a transaction completes at a
// rising edge with push high and full low. i_line_last marks the final
// byte of a line. Results leave through a second queue-style port: while
// empty is low the oldest result is on the o_ ports, and it is taken at an
// edge with pop high. A byte causes zero, one or two results; o_item_last
// marks the last one of each byte.
// An accepted byte's command is written to the four-entry command queue
// between the parser and the result sequencer to absorb stalls. While
// full is low the parser takes one byte per cycle. A byte that ends a line
// on a space yields two results and holds its queue entry for two pops.
// When the receiver stops popping, the queue fills and full rises after
// four commands wait; bytes that cause no result take no queue entry.
// Reset (synchronous, active low) empties the queue and returns the
// parser to the start-of-line state.
// ============================================================================
`default_nettype none

module quoted_token_splitter_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_line_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_token_end,
    output logic            o_line_end,
    output logic [2:0]      o_error_code,
    output logic            o_item_last
);
    import qts_pkg::*;

    t_cmd   cmd;
    logic   cmd_valid;
    t_cmd   head;
    t_qstat qstat;
    logic   q_rd;
    logic   accept;

    assign full   = qstat.full;
    assign accept = push && !qstat.full;

    // Parser
    qts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_line_last (i_line_last),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid)
    );

    // Command queue
    qts_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (accept && cmd_valid),
        .i_wr_cmd (cmd),
        .i_rd     (q_rd),
        .o_head   (head),
        .o_stat   (qstat)
    );

    // Result sequencer
    qts_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_stat       (qstat),
        .i_pop        (pop),
        .o_q_rd       (q_rd),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_token_end  (o_token_end),
        .o_line_end   (o_line_end),
        .o_error_code (o_error_code),
        .o_item_last  (o_item_last)
    );

    // An error result carries line end and nothing else.
    a_error_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code != ERR_NONE) |->
            (o_line_end && !o_byte_valid && !o_token_end && o_item_last))
        else $error("error result with unexpected fields");

    // The first of two results is a plain token end.
    a_first_of_two : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_item_last) |-> (o_token_end && !o_line_end && !o_byte_valid))
        else $error("first of two results malformed");

    // Taking the first of two results leaves the empty final token waiting.
    a_second_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_item_last && pop) |=>
            (!empty && o_token_end && o_line_end && o_item_last))
        else $error("empty final token did not follow");

    // A full queue always has a result to offer.
    a_full_not_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("queue full and empty at once");

endmodule

`default_nettype wire

// ----- test/quoted_token_splitter_top_tb.sv -----
// ============================================================================
// Quoted token splitter testbench
// Drives command lines byte by byte into the splitter and checks every result
// against a built-in tokeniser model: a short table of hand-picked lines
// first, then random lines, most of them well formed, some broken, some noise,
// with random idling on both queue ports.
// ============================================================================
`timescale 1ns / 1ps

module quoted_token_splitter_top_tb;

    import qts_pkg::*;

    // One result of the splitter
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       tend;
        logic       lend;
        logic [2:0] err;
        logic       ilast;
    } t_piece;

    // One row of the directed table; nres of PRED means the model decides
    typedef struct {
        logic [7:0] c;
        logic       last;
        int         nres;
        t_piece     ans;
    } t_row;

    localparam int     PRED      = -1;
    localparam int     N_ROWS    = 27;
    localparam int     RUN_ITEMS = 2000;
    localparam t_piece NONE      = '0;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_line_last = 1'b0;
    logic       pop         = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_token_end;
    logic       o_line_end;
    logic [2:0] o_error_code;
    logic       o_item_last;

    // Tokeniser model state
    t_mode      pmode       = MODE_NORMAL;
    logic       after_space = 1'b0;
    logic       bs_odd      = 1'b0;

    t_piece     token_q[$];
    logic [7:0] line_buf[$];
    t_row       dir_rows [N_ROWS];

    bit         rst_done  = 1'b0;
    bit         tx_fast   = 1'b0;
    bit         rx_fast   = 1'b0;
    int         n_fail    = 0;
    int         n_bytes   = 0;
    int         n_lines   = 0;
    int         n_checked = 0;
    int         n_tokens  = 0;
    int         n_held    = 0;
    int         n_aborts [8];

    quoted_token_splitter_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_byte    (i_in_byte),
        .i_line_last  (i_line_last),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_token_end  (o_token_end),
        .o_line_end   (o_line_end),
        .o_error_code (o_error_code),
        .o_item_last  (o_item_last)
    );

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #1_000_000;
        $display("quoted_token_splitter_top_tb: errors");
        $finish;
    end

    function automatic t_piece piece(logic [7:0] d, logic v, logic te, logic le,
                                     logic [2:0] e);
        return '{d, v, te, le, e, 1'b0};
    endfunction

    // The single result of a line that is aborted
    function automatic t_piece abort_piece(logic [2:0] e);
        return '{8'h00, 1'b0, 1'b0, 1'b1, e, 1'b1};
    endfunction

    // Tokeniser model: works out the results of one byte and moves the state on.
    task automatic split_char(input logic [7:0] c, input logic last, output int n,
                              output t_piece r [2]);
        logic [2:0] fault;
        bit         spc;
        fault = ERR_NONE;
        spc   = 1'b0;
        n     = 1;
        r[0]  = NONE;
        r[1]  = NONE;
        case (pmode)
            MODE_NORMAL: begin
                if (c == CH_QUOTE) begin
                    if (!after_space) begin
                        fault = ERR_LEADING;
                    end else if (last) begin
                        fault = ERR_EMPTY;
                    end else begin
                        r[0]        = piece(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
                        pmode       = MODE_Q_OPEN;
                        after_space = 1'b0;
                        bs_odd      = 1'b0;
                    end
                end else if (c == CH_SPACE) begin
                    spc = 1'b1;
                end else begin
                    r[0]        = piece(c, 1'b1, last, last, ERR_NONE);
                    after_space = 1'b0;
                end
            end
            MODE_Q_OPEN: begin
                if (c == CH_QUOTE || last) begin
                    fault = ERR_EMPTY;
                end else begin
                    r[0]   = piece(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    bs_odd = (c == CH_BSLASH);
                    pmode  = MODE_Q_BODY;
                end
            end
            MODE_Q_BODY: begin
                if (c == CH_QUOTE) begin
                    if (bs_odd) begin
                        // Escaped quote stays inside the string
                        if (last) begin
                            fault = ERR_ESCAPED;
                        end else begin
                            r[0]   = piece(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
                            bs_odd = 1'b0;
                        end
                    end else begin
                        r[0]   = piece(c, 1'b1, last, last, ERR_NONE);
                        bs_odd = 1'b0;
                        pmode  = MODE_Q_CLOSED;
                    end
                end else if (last) begin
                    fault = ERR_UNTERM;
                end else begin
                    r[0]   = piece(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    bs_odd = (c == CH_BSLASH) ? !bs_odd : 1'b0;
                end
            end
            MODE_Q_CLOSED: begin
                if (c == CH_SPACE) begin
                    spc = 1'b1;
                end else begin
                    fault = ERR_TRAILING;
                end
            end
            default: begin
                n = 0;
            end
        endcase
        if (fault != ERR_NONE) begin
            r[0]  = piece(8'h00, 1'b0, 1'b0, 1'b1, fault);
            pmode = MODE_DROP;
        end
        // A space ends the token; at line end an empty token follows
        if (spc) begin
            r[0] = piece(8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
            if (last) begin
                r[1] = piece(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
                n    = 2;
            end else begin
                pmode       = MODE_NORMAL;
                after_space = 1'b1;
            end
        end
        if (n > 0) begin
            r[n-1].ilast = 1'b1;
        end
        if (last) begin
            pmode       = MODE_NORMAL;
            after_space = 1'b0;
            bs_odd      = 1'b0;
        end
    endtask

    // Sends one byte after a random gap and books the results it causes.
    task automatic send_char(input logic [7:0] c, input logic last, input int nres,
                             input t_piece ans);
        int     gap;
        int     n;
        t_piece r [2];
        gap = tx_fast ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_in_byte   <= c;
        i_line_last <= last;
        forever begin
            @(posedge i_clk);
            if (!full) break;
            n_held++;
        end
        split_char(c, last, n, r);
        if (nres != PRED) begin
            n    = nres;
            r[0] = ans;
        end
        for (int i = 0; i < n; i++) begin
            token_q = {token_q, r[i]};
        end
        n_bytes++;
        if (last) n_lines++;
    endtask

    // Compares one popped transaction with the oldest booked result.
    task automatic take_result();
        t_piece want;
        if (token_q.size() == 0) begin
            $error("result with nothing due: out_byte %h line_end %b error_code %0d",
                   o_out_byte, o_line_end, o_error_code);
            n_fail++;
            return;
        end
        want = token_q.pop_front();
        if (o_out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, o_out_byte);
            n_fail++;
        end
        if (o_byte_valid !== want.valid) begin
            $error("byte_valid: expected %b, got %b", want.valid, o_byte_valid);
            n_fail++;
        end
        if (o_token_end !== want.tend) begin
            $error("token_end: expected %b, got %b", want.tend, o_token_end);
            n_fail++;
        end
        if (o_line_end !== want.lend) begin
            $error("line_end: expected %b, got %b", want.lend, o_line_end);
            n_fail++;
        end
        if (o_error_code !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, o_error_code);
            n_fail++;
        end
        if (o_item_last !== want.ilast) begin
            $error("item_last: expected %b, got %b", want.ilast, o_item_last);
            n_fail++;
        end
        n_checked++;
        if (want.tend) n_tokens++;
        n_aborts[want.err]++;
    endtask

    // Any byte but a space or a quote, backslash only where allowed
    function automatic logic [7:0] plain_char(bit allow_bs);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_SPACE || c == CH_QUOTE || (!allow_bs && c == CH_BSLASH));
        if (allow_bs && $urandom_range(0, 7) == 0) c = CH_BSLASH;
        return c;
    endfunction

    // A byte biased towards the characters the parser cares about
    function automatic logic [7:0] odd_char();
        case ($urandom_range(0, 4))
            0:       return CH_QUOTE;
            1:       return CH_SPACE;
            2:       return CH_BSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Builds a well-formed line of plain and quoted tokens.
    task automatic compose_clean();
        int ntok;
        int len;
        line_buf.delete();
        if ($urandom_range(0, 5) == 0) line_buf = {line_buf, CH_SPACE};
        ntok = $urandom_range(1, 4);
        for (int t = 0; t < ntok; t++) begin
            if (t > 0) begin
                line_buf = {line_buf, CH_SPACE};
                if ($urandom_range(0, 9) == 0) line_buf = {line_buf, CH_SPACE};
            end
            if (line_buf.size() > 0 && line_buf[$] == CH_SPACE &&
                    $urandom_range(0, 1) == 0) begin
                // Quoted string: body elements keep backslash runs balanced
                line_buf = {line_buf, CH_QUOTE};
                len = $urandom_range(1, 6);
                repeat (len) begin
                    case ($urandom_range(0, 5))
                        0: line_buf = {line_buf, CH_SPACE};
                        1: begin
                            line_buf = {line_buf, CH_BSLASH, CH_BSLASH};
                        end
                        2: begin
                            line_buf = {line_buf, CH_BSLASH, CH_QUOTE};
                        end
                        default: line_buf = {line_buf, plain_char(1'b0)};
                    endcase
                end
                line_buf = {line_buf, CH_QUOTE};
            end else begin
                len = $urandom_range(1, 5);
                repeat (len) line_buf = {line_buf, plain_char(1'b1)};
            end
        end
        if ($urandom_range(0, 4) == 0) line_buf = {line_buf, CH_SPACE};
    endtask

    // Breaks a line: cut it short or overwrite one byte.
    task automatic mangle_line();
        int pos;
        if (line_buf.size() > 1 && $urandom_range(0, 2) == 0) begin
            pos = $urandom_range(1, line_buf.size() - 1);
            line_buf = line_buf[0:pos-1];
        end else begin
            pos = $urandom_range(0, line_buf.size() - 1);
            line_buf[pos] = odd_char();
        end
    endtask

    // Result side: random stalls, with stretches of back-to-back pops
    initial begin
        int stall;
        wait (rst_done);
        forever begin
            if ($urandom_range(0, 49) == 0) rx_fast = ($urandom_range(0, 3) == 0);
            stall = rx_fast ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            take_result();
        end
    end

    // Stimulus and end of run
    initial begin
        int  pick;
        bit  paused;
        paused = 1'b0;
        foreach (n_aborts[k]) n_aborts[k] = 0;

        // Hand-picked lines: every error code, drops, extremes of the byte
        dir_rows = '{
            '{CH_QUOTE,  1'b0, 1,    abort_piece(ERR_LEADING)},
            '{8'hFF,     1'b1, 0,    NONE},
            '{8'h00,     1'b0, PRED, NONE},
            '{CH_SPACE,  1'b0, PRED, NONE},
            '{CH_QUOTE,  1'b1, 1,    abort_piece(ERR_EMPTY)},
            '{CH_SPACE,  1'b0, PRED, NONE},
            '{CH_QUOTE,  1'b0, PRED, NONE},
            '{CH_QUOTE,  1'b1, 1,    abort_piece(ERR_EMPTY)},
            '{CH_SPACE,  1'b0, PRED, NONE},
            '{CH_QUOTE,  1'b0, PRED, NONE},
            '{"b",       1'b1, 1,    abort_piece(ERR_EMPTY)},
            '{CH_SPACE,  1'b0, PRED, NONE},
            '{CH_QUOTE,  1'b0, PRED, NONE},
            '{CH_BSLASH, 1'b0, PRED, NONE},
            '{CH_QUOTE,  1'b0, PRED, NONE},
            '{CH_QUOTE,  1'b0, PRED, NONE},
            '{"z",       1'b1, 1,    abort_piece(ERR_TRAILING)},
            '{CH_BSLASH, 1'b0, PRED, NONE},
            '{CH_SPACE,  1'b0, PRED, NONE},
            '{CH_QUOTE,  1'b0, PRED, NONE},
            '{"a",       1'b0, PRED, NONE},
            '{"b",       1'b1, 1,    abort_piece(ERR_UNTERM)},
            '{CH_SPACE,  1'b0, PRED, NONE},
            '{CH_QUOTE,  1'b0, PRED, NONE},
            '{CH_BSLASH, 1'b0, PRED, NONE},
            '{CH_QUOTE,  1'b1, 1,    abort_piece(ERR_ESCAPED)},
            '{CH_SPACE,  1'b1, PRED, NONE}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done  = 1'b1;

        foreach (dir_rows[k]) begin
            send_char(dir_rows[k].c, dir_rows[k].last, dir_rows[k].nres, dir_rows[k].ans);
        end

        // Random lines: mostly well formed, some broken, some noise
        while (n_bytes < RUN_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 9) begin
                compose_clean();
                if (pick >= 7) mangle_line();
            end else begin
                line_buf.delete();
                repeat ($urandom_range(1, 8)) line_buf = {line_buf, odd_char()};
            end
            tx_fast = ($urandom_range(0, 3) == 0);
            foreach (line_buf[i]) begin
                send_char(line_buf[i], i == line_buf.size() - 1, PRED, NONE);
            end
            // Once, halfway, let the result side run dry
            if (!paused && n_bytes >= RUN_ITEMS / 2) begin
                paused  = 1'b1;
                push   <= 1'b0;
                do @(posedge i_clk); while (token_q.size() != 0);
            end
        end

        push <= 1'b0;
        do @(posedge i_clk); while (token_q.size() != 0);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d bytes in %0d lines; checked %0d results, %0d of them token ends.",
                 n_bytes, n_lines, n_checked, n_tokens);
        $display("Aborted lines by code 1 to 5: %0d %0d %0d %0d %0d; %0d cycles held off by full.",
                 n_aborts[1], n_aborts[2], n_aborts[3], n_aborts[4], n_aborts[5], n_held);
        if (n_fail == 0) begin
            $display("quoted_token_splitter_top_tb: clean");
        end else begin
            $display("quoted_token_splitter_top_tb: errors");
        end
        $finish;
    end

endmodule
